>>> sv/sha1_pkg.sv
package sha1_pkg;

  localparam int NUM_CHAIN = 5;
  localparam int WIN_WORDS = 16;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_OUT   = 3'd4;
  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [3:0] LAST_WORD  = 4'd15;
  localparam logic [31:0] PAD_WORD  = 32'h8000_0000;

  localparam logic [31:0] H_INIT [NUM_CHAIN] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD80,
    ST_PADZ,
    ST_LENHI,
    ST_LENLO,
    ST_OUT
  } state_t;

  // source of the bytes fed to the packer
  typedef enum logic [2:0] {
    SRC_DATA,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LENHI,
    SRC_LENLO
  } src_t;

  typedef struct packed {
    logic       in_ready;
    logic       absorb_en;
    src_t       src;
    logic       load_en;
    logic       round_en;
    logic [6:0] round_idx;
    logic       fold_en;
    logic       clear_en;
    logic       out_valid;
    logic [2:0] out_idx;
  } ctl_t;

  typedef struct packed {
    logic blk_full;
    logic at_len;
    logic fin;
  } sts_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) begin
      k = 32'h5A82_7999;
    end else if (t < 7'd40) begin
      k = 32'h6ED9_EBA1;
    end else if (t < 7'd60) begin
      k = 32'h8F1B_BCDC;
    end else begin
      k = 32'hCA62_C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

>>> sv/sha1_round.sv
// Compression unit: schedule window, working variables, chaining values.
module sha1_round (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1_pkg::ctl_t      ctl,
  input  logic                push_en,
  input  logic [31:0]         push_word,
  output logic [31:0]         digest_word
);

  logic [31:0] win_r   [sha1_pkg::WIN_WORDS];
  logic [31:0] chain_r [sha1_pkg::NUM_CHAIN];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [31:0] tmp;

  // window slides one word per round or per pushed word; during rounds win_r[0] is W(t)
  assign w_mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  assign tmp = {a_r[26:0], a_r[31:27]}
             + sha1_pkg::round_f(ctl.round_idx, b_r, c_r, d_r)
             + e_r + win_r[0] + sha1_pkg::round_k(ctl.round_idx);

  always_ff @(posedge clk) begin
    if (push_en || ctl.round_en) begin
      for (int i = 0; i < sha1_pkg::WIN_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[sha1_pkg::WIN_WORDS-1] <= push_en ? push_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_en) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (ctl.round_en) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear_en) begin
      for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
        chain_r[i] <= sha1_pkg::H_INIT[i];
      end
    end else if (ctl.fold_en) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r;
    end
  end

  always_comb begin
    case (ctl.out_idx)
      3'd0:    digest_word = chain_r[0];
      3'd1:    digest_word = chain_r[1];
      3'd2:    digest_word = chain_r[2];
      3'd3:    digest_word = chain_r[3];
      3'd4:    digest_word = chain_r[4];
      default: digest_word = chain_r[0];
    endcase
  end

endmodule

>>> sv/sha1_ctrl.sv
// Sequencer: absorb, padding, 80 rounds, fold, digest readout.
module sha1_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  input  sha1_pkg::sts_t sts,
  output sha1_pkg::ctl_t ctl
);

  sha1_pkg::state_t state_r, state_nxt;
  sha1_pkg::state_t ret_r, ret_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [2:0] oidx_r, oidx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1_pkg::ST_IDLE;
      ret_r   <= sha1_pkg::ST_IDLE;
      rnd_r   <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (sts.blk_full) begin
            state_nxt = sha1_pkg::ST_ROUND;
            ret_nxt   = sts.fin ? sha1_pkg::ST_PAD80 : sha1_pkg::ST_IDLE;
          end else if (sts.fin) begin
            state_nxt = sha1_pkg::ST_PAD80;
          end
        end
      end
      sha1_pkg::ST_PAD80: begin
        if (sts.blk_full) begin
          state_nxt = sha1_pkg::ST_ROUND;
          ret_nxt   = sha1_pkg::ST_PADZ;
        end else begin
          state_nxt = sha1_pkg::ST_PADZ;
        end
      end
      sha1_pkg::ST_PADZ: begin
        if (sts.at_len) begin
          state_nxt = sha1_pkg::ST_LENHI;
        end else if (sts.blk_full) begin
          state_nxt = sha1_pkg::ST_ROUND;
          ret_nxt   = sha1_pkg::ST_PADZ;
        end
      end
      sha1_pkg::ST_LENHI: begin
        state_nxt = sha1_pkg::ST_LENLO;
      end
      sha1_pkg::ST_LENLO: begin
        state_nxt = sha1_pkg::ST_ROUND;
        ret_nxt   = sha1_pkg::ST_OUT;
      end
      sha1_pkg::ST_ROUND: begin
        if (rnd_r == sha1_pkg::LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = sha1_pkg::ST_FOLD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end
      sha1_pkg::ST_FOLD: begin
        state_nxt = ret_r;
      end
      sha1_pkg::ST_OUT: begin
        if (out_ready) begin
          if (oidx_r == sha1_pkg::LAST_OUT) begin
            oidx_nxt  = '0;
            state_nxt = sha1_pkg::ST_IDLE;
            ret_nxt   = sha1_pkg::ST_IDLE;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl           = '0;
    ctl.src       = sha1_pkg::SRC_DATA;
    ctl.round_idx = rnd_r;
    ctl.out_idx   = oidx_r;
    case (state_r)
      sha1_pkg::ST_IDLE: begin
        ctl.in_ready  = 1'b1;
        ctl.absorb_en = in_valid;
      end
      sha1_pkg::ST_PAD80: begin
        ctl.absorb_en = 1'b1;
        ctl.src       = sha1_pkg::SRC_PAD80;
      end
      sha1_pkg::ST_PADZ: begin
        ctl.absorb_en = !sts.at_len;
        ctl.src       = sha1_pkg::SRC_ZERO;
      end
      sha1_pkg::ST_LENHI: begin
        ctl.absorb_en = 1'b1;
        ctl.src       = sha1_pkg::SRC_LENHI;
      end
      sha1_pkg::ST_LENLO: begin
        ctl.absorb_en = 1'b1;
        ctl.src       = sha1_pkg::SRC_LENLO;
      end
      sha1_pkg::ST_ROUND: begin
        ctl.round_en = 1'b1;
      end
      sha1_pkg::ST_FOLD: begin
        ctl.fold_en = 1'b1;
      end
      sha1_pkg::ST_OUT: begin
        ctl.out_valid = 1'b1;
        ctl.clear_en  = out_ready && (oidx_r == sha1_pkg::LAST_OUT);
      end
      default: begin
        ctl.in_ready = 1'b0;
      end
    endcase
    ctl.load_en = ctl.absorb_en && sts.blk_full;
  end

`ifndef NO_ASSERTIONS
  a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::ST_ROUND && rnd_r == sha1_pkg::LAST_ROUND)
      |=> (state_r == sha1_pkg::ST_FOLD))
    else $error("last round not followed by fold");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::ST_IDLE) |-> (rnd_r == '0 && oidx_r == '0))
    else $error("counters not clear while idle");

  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::ST_OUT && out_ready && oidx_r == sha1_pkg::LAST_OUT)
      |=> (state_r == sha1_pkg::ST_IDLE && ret_r == sha1_pkg::ST_IDLE))
    else $error("digest readout did not return to idle");
`endif

endmodule

>>> sv/sha1_hash_engine.sv
// Channel | Direction | Ports                                    | Handshake
// in      | input     | in_message_word, in_byte_count, in_final_word | in_valid / in_ready
// out     | output    | out_digest_word, out_digest_end          | out_valid / out_ready
//
// Flow: a word is taken when in_valid meets in_ready. The 16th word of a block starts the
//   shared round unit: 80 rounds, then a fold; no new word is taken meanwhile.
// A final word adds padding steps (the 0x80 byte, zero fill up to the length position,
//   then the two length words), possibly a second block, then five digest words.
// Reset: rst_n synchronous, active low; chaining values load the initial
//   values, byte position, partial word and bit length clear.
// Stalls: in_ready is high only while idle; out_valid holds until each digest
//   word is taken, and the engine reloads itself after the fifth.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_final_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic        out_digest_end
);

  sha1_pkg::ctl_t ctl;
  sha1_pkg::sts_t sts;

  logic [5:0]  pos_r, pos_nxt;     // byte position within the block
  logic [23:0] part_r, part_nxt;   // bytes of the word being assembled
  logic [63:0] len_r, len_nxt;     // message bit count

  logic [1:0]  off;
  logic [31:0] src_word;
  logic [2:0]  src_cnt;
  logic [31:0] new_bytes;
  logic [55:0] comb;
  logic [2:0]  total;
  logic [1:0]  rem;
  logic        complete;
  logic [55:0] done_shift;
  logic [23:0] part_keep;
  logic        push_en;

  assign off = pos_r[1:0];

  // byte source for the packer
  always_comb begin
    case (ctl.src)
      sha1_pkg::SRC_DATA: begin
        src_word = in_message_word;
        src_cnt  = (in_byte_count > sha1_pkg::WORD_BYTES) ? sha1_pkg::WORD_BYTES
                                                            : in_byte_count;
      end
      sha1_pkg::SRC_PAD80: begin
        src_word = sha1_pkg::PAD_WORD;
        src_cnt  = 3'd1;
      end
      sha1_pkg::SRC_ZERO: begin
        // zero bytes up to the next word boundary
        src_word = '0;
        src_cnt  = (off == 2'd0) ? sha1_pkg::WORD_BYTES
                                 : (sha1_pkg::WORD_BYTES - {1'b0, off});
      end
      sha1_pkg::SRC_LENHI: begin
        src_word = len_r[63:32];
        src_cnt  = sha1_pkg::WORD_BYTES;
      end
      sha1_pkg::SRC_LENLO: begin
        src_word = len_r[31:0];
        src_cnt  = sha1_pkg::WORD_BYTES;
      end
      default: begin
        src_word = '0;
        src_cnt  = '0;
      end
    endcase
  end

  // right-align the valid top bytes
  always_comb begin
    case (src_cnt)
      3'd1:    new_bytes = {24'd0, src_word[31:24]};
      3'd2:    new_bytes = {16'd0, src_word[31:16]};
      3'd3:    new_bytes = {8'd0,  src_word[31:8]};
      3'd4:    new_bytes = src_word;
      default: new_bytes = '0;
    endcase
  end

  // partial bytes followed by the new ones, up to seven bytes
  assign comb       = ({32'd0, part_r} << {src_cnt, 3'b000}) | {24'd0, new_bytes};
  assign total      = {1'b0, off} + src_cnt;
  assign complete   = total[2];
  assign rem        = total[1:0];
  assign done_shift = comb >> {rem, 3'b000};

  always_comb begin
    case (rem)
      2'd1:    part_keep = {16'd0, comb[7:0]};
      2'd2:    part_keep = {8'd0,  comb[15:0]};
      2'd3:    part_keep = comb[23:0];
      default: part_keep = '0;
    endcase
  end

  assign part_nxt = complete ? part_keep : comb[23:0];
  assign pos_nxt  = pos_r + {3'd0, src_cnt};
  assign len_nxt  = len_r + {58'd0, src_cnt, 3'b000};
  assign push_en  = ctl.absorb_en && complete;

  assign sts.blk_full = complete && (pos_r[5:2] == sha1_pkg::LAST_WORD);
  assign sts.at_len   = (pos_r == sha1_pkg::LEN_POS);
  assign sts.fin      = in_final_word;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear_en) begin
      pos_r  <= '0;
      part_r <= '0;
      len_r  <= '0;
    end else if (ctl.absorb_en) begin
      pos_r  <= pos_nxt;
      part_r <= part_nxt;
      if (ctl.src == sha1_pkg::SRC_DATA) begin
        len_r <= len_nxt;
      end
    end
  end

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  sha1_round u_round (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .push_en     (push_en),
    .push_word   (done_shift[31:0]),
    .digest_word (out_digest_word)
  );

  assign in_ready       = ctl.in_ready;
  assign out_valid      = ctl.out_valid;
  assign out_digest_end = (ctl.out_idx == sha1_pkg::LAST_OUT);

`ifndef NO_ASSERTIONS
  a_len_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.absorb_en && ctl.src == sha1_pkg::SRC_LENLO) |-> sts.blk_full)
    else $error("length word does not close the block");
`endif

endmodule
